[src/sfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the sensor frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [POS_W-1:0]  FRAME_LAST  = 4'd10;
  localparam logic [POS_W-1:0]  SONIC_FIRST = 4'd1;
  localparam logic [POS_W-1:0]  SONIC_LAST  = 4'd4;
  localparam logic [POS_W-1:0]  PHOTO_FIRST = 4'd5;
  localparam logic [POS_W-1:0]  PHOTO_LAST  = 4'd8;
  localparam logic [POS_W-1:0]  SUM_POS     = 4'd9;
  localparam logic [BYTE_W-1:0] START_RESET = 8'h55;

  typedef enum logic [STATUS_W-1:0] {
    ST_GOOD      = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BAD_SUM   = 2'd2
  } sfd_status_t;

  // One finished frame, as handed from the frame core to the output stage.
  typedef struct packed {
    logic               valid;
    logic [WORD_W-1:0]  sonic_bits;
    logic [WORD_W-1:0]  photo_value;
    sfd_status_t        status;
  } sfd_result_t;

endpackage

`default_nettype wire

[src/sfd_frame_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_frame_core
// Byte position tracking, XOR checksum, start check and little-endian
// payload assembly. Emits one result on the last byte of each frame.
// ----------------------------------------------------------------------------
module sfd_frame_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  input  wire logic [sfd_pkg::BYTE_W-1:0]  cfg_data,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [sfd_pkg::BYTE_W-1:0]  in_byte,
  input  wire logic                        in_begin,
  input  wire logic                        res_space,
  output sfd_pkg::sfd_result_t             res
);
  import sfd_pkg::*;

  logic [BYTE_W-1:0] marker_r;
  logic [POS_W-1:0]  pos_r, pos_nxt, pos;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic              start_good_r, start_good_nxt;
  logic              sum_bad_r, sum_bad_nxt;
  logic [WORD_W-1:0] sonic_r, sonic_nxt;
  logic [WORD_W-1:0] photo_r, photo_nxt;
  logic              accept;

  // Only the closing byte needs room in the output stage.
  assign in_tready = res_space || (pos_r != FRAME_LAST);
  assign accept    = in_tvalid && in_tready;
  assign pos       = in_begin ? '0 : pos_r;

  always_comb begin
    pos_nxt        = (pos >= FRAME_LAST) ? '0 : pos + 1'b1;
    xor_nxt        = xor_r;
    start_good_nxt = start_good_r;
    sum_bad_nxt    = sum_bad_r;
    sonic_nxt      = sonic_r;
    photo_nxt      = photo_r;
    res.valid       = 1'b0;
    res.sonic_bits  = sonic_r;
    res.photo_value = photo_r;
    if (!start_good_r) begin
      res.status = ST_BAD_START;
    end else if (sum_bad_r) begin
      res.status = ST_BAD_SUM;
    end else begin
      res.status = ST_GOOD;
    end
    case (pos) inside
      4'd0: begin
        start_good_nxt = (in_byte == marker_r);
        sum_bad_nxt    = 1'b0;
        xor_nxt        = in_byte;
        sonic_nxt      = '0;
        photo_nxt      = '0;
      end
      [SONIC_FIRST:SONIC_LAST]: begin
        xor_nxt   = xor_r ^ in_byte;
        sonic_nxt = {in_byte, sonic_r[WORD_W-1:BYTE_W]};
      end
      [PHOTO_FIRST:PHOTO_LAST]: begin
        xor_nxt   = xor_r ^ in_byte;
        photo_nxt = {in_byte, photo_r[WORD_W-1:BYTE_W]};
      end
      SUM_POS: begin
        sum_bad_nxt = (in_byte != xor_r);
      end
      default: begin
        // closing byte: taken, not checked
        res.valid = accept;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r     <= START_RESET;
      pos_r        <= '0;
      xor_r        <= '0;
      start_good_r <= 1'b0;
      sum_bad_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        marker_r <= cfg_data;
      end
      if (accept) begin
        pos_r        <= pos_nxt;
        xor_r        <= xor_nxt;
        start_good_r <= start_good_nxt;
        sum_bad_r    <= sum_bad_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sonic_r <= sonic_nxt;
      photo_r <= photo_nxt;
    end
  end

endmodule

`default_nettype wire

[src/sfd_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_out_stage
// Result register: holds a finished frame until the output side takes it.
// ----------------------------------------------------------------------------
module sfd_out_stage (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire sfd_pkg::sfd_result_t              res,
  output logic                                   res_space,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [sfd_pkg::OUT_TDATA_W-1:0]        out_tdata
);
  import sfd_pkg::*;

  logic              valid_r;
  logic [WORD_W-1:0] sonic_r;
  logic [WORD_W-1:0] photo_r;
  sfd_status_t       status_r;

  assign res_space  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-2*WORD_W-STATUS_W){1'b0}}, status_r, photo_r, sonic_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_space) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_space && res.valid) begin
      sonic_r  <= res.sonic_bits;
      photo_r  <= res.photo_value;
      status_r <= res.status;
    end
  end

endmodule

`default_nettype wire

[src/sensor_frame_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_frame_deframer
// Reads 11-byte sensor frames (start, 4 sonic, 4 photo, checksum, end) and
// returns the assembled payloads with a status word per frame.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / data             | tuser
//  in_     | slave     | [7:0] data_byte          | [0] frame_begin
//  out_    | master    | [31:0] sonic_bits,       | -
//          |           | [63:32] photo_value,     |
//          |           | [65:64] status           |
//  cfg_    | write     | [7:0] start_marker       | -
//
//  One byte word is taken per cycle while in_tready is high; the frame result
//  shows on out_ in the cycle after the closing byte is taken, from the result register.
//  The input stalls only while the byte position sits on the closing byte
//  (even when the waiting word carries frame_begin) and the result register
//  still holds an untaken frame; all other bytes pass regardless of out_tready.
//  Reset (rst_n low, synchronous) clears the byte position, checksum flags
//  and the result valid, and sets start_marker to 0x55.
// ----------------------------------------------------------------------------
module sensor_frame_deframer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [sfd_pkg::BYTE_W-1:0]         cfg_data,   // [7:0] start_marker
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [sfd_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] data_byte
  input  wire logic                               in_tuser,   // [0] frame_begin
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [sfd_pkg::OUT_TDATA_W-1:0]         out_tdata   // [31:0] sonic_bits,
                                                              // [63:32] photo_value,
                                                              // [65:64] status
);
  import sfd_pkg::*;

  sfd_result_t res;
  logic        res_space;

  assign cfg_ready = 1'b1;

  sfd_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_begin  (in_tuser),
    .res_space (res_space),
    .res       (res)
  );

  sfd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .res_space  (res_space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

[src/sfd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks for the sensor frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [sfd_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import sfd_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed or dropped");

  // a result word only follows a taken byte
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result word without a taken byte");

  // status never uses the unassigned code, padding stays zero
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2*WORD_W+STATUS_W-1:2*WORD_W] != 2'b11
                   && out_tdata[OUT_TDATA_W-1:2*WORD_W+STATUS_W] == '0)
    else $error("bad status code or padding");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (.*);

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sensor_frame_deframer. Feeds byte words on the
// input stream and keeps its own model of the frame reader. The model runs
// on every accepted byte and queues each frame it closes. Each word taken
// from the result stream is checked field by field against the oldest
// queued frame. Traffic is a short directed set of frames, then random
// frames, truncated frames and loose bytes. The start marker changes between
// phases, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import sfd_pkg::*;

  typedef struct {
    logic [WORD_W-1:0]        sonic;
    logic signed [WORD_W-1:0] photo;
    sfd_status_t              status;
  } frame_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [BYTE_W-1:0]      cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // model of the frame reader
  logic [BYTE_W-1:0] marker_m = START_RESET;
  logic [POS_W-1:0]  pos_m    = '0;
  logic [BYTE_W-1:0] xor_m    = '0;
  logic              good_m   = 1'b0;
  logic              bad_m    = 1'b0;
  logic [WORD_W-1:0] sonic_m  = '0;
  logic [WORD_W-1:0] photo_m  = '0;
  frame_t            frames_due[$];

  logic [BYTE_W-1:0] cur_marker = START_RESET;
  logic              calm       = 1'b0;
  int                hold_left  = 0;
  int                bytes_sent = 0;
  int                errors     = 0;

  sensor_frame_deframer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stalls, a counted hold-off when one is requested, or always ready while calm.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 6);
    end
  end

  function automatic void note_mismatch(string what, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endfunction

  task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic begin_flag);
    logic [POS_W-1:0] p;
    frame_t           f;
    p = begin_flag ? '0 : pos_m;
    if (p > FRAME_LAST)
      p = '0;
    if (p == 0) begin
      good_m  = (b == marker_m);
      bad_m   = 1'b0;
      xor_m   = b;
      sonic_m = '0;
      photo_m = '0;
    end else if (p <= SONIC_LAST) begin
      xor_m   = xor_m ^ b;
      sonic_m = {b, sonic_m[WORD_W-1:BYTE_W]};
    end else if (p <= PHOTO_LAST) begin
      xor_m   = xor_m ^ b;
      photo_m = {b, photo_m[WORD_W-1:BYTE_W]};
    end else if (p == SUM_POS) begin
      bad_m = (b != xor_m);
    end else begin
      f.sonic  = sonic_m;
      f.photo  = photo_m;
      // start check wins over the checksum check
      f.status = !good_m ? ST_BAD_START : (bad_m ? ST_BAD_SUM : ST_GOOD);
      frames_due.push_back(f);
    end
    pos_m = (p >= FRAME_LAST) ? '0 : p + 1'b1;
  endtask

  // Check results first, then advance the model on accepted words.
  always @(posedge clk) begin
    frame_t f;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (frames_due.size() == 0) begin
          note_mismatch("unexpected result, tdata[31:0]", 'x, out_tdata[31:0]);
        end else begin
          f = frames_due.pop_front();
          if (out_tdata[31:0] !== f.sonic)
            note_mismatch("sonic_bits", f.sonic, out_tdata[31:0]);
          if (out_tdata[63:32] !== f.photo)
            note_mismatch("photo_value", f.photo, out_tdata[63:32]);
          if (out_tdata[65:64] !== f.status)
            note_mismatch("status", 32'(f.status), 32'(out_tdata[65:64]));
          if (out_tdata[OUT_TDATA_W-1:66] !== '0)
            note_mismatch("pad bits", '0, 32'(out_tdata[OUT_TDATA_W-1:66]));
        end
      end
      if (cfg_valid && cfg_ready)
        marker_m = cfg_data;
      if (in_tvalid && in_tready)
        deframe_byte(in_tdata, in_tuser);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic begin_flag);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= begin_flag;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] b0, input logic [WORD_W-1:0] sonic,
                            input logic [WORD_W-1:0] photo, input bit sum_ok,
                            input logic begin_flag);
    logic [BYTE_W-1:0] sum;
    sum = b0;
    send_byte(b0, begin_flag);
    for (int i = 0; i < 4; i++) begin
      sum ^= sonic[8*i +: 8];
      send_byte(sonic[8*i +: 8], 1'b0);
    end
    for (int i = 0; i < 4; i++) begin
      sum ^= photo[8*i +: 8];
      send_byte(photo[8*i +: 8], 1'b0);
    end
    if (!sum_ok)
      sum ^= 8'($urandom_range(1, 255));
    send_byte(sum, 1'b0);
    send_byte(8'($urandom), 1'b0);   // end byte, not checked
  endtask

  function automatic logic [BYTE_W-1:0] wrong_start();
    return cur_marker ^ 8'($urandom_range(1, 255));
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (frames_due.size() != 0);
    @(posedge clk);
  endtask

  task automatic set_marker(input logic [BYTE_W-1:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid  <= 1'b0;
    cur_marker  = v;
  endtask

  task automatic test_directed();
    send_frame(cur_marker, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
    // back to back, no begin flag
    send_frame(cur_marker, 32'h0000_0000, 32'h8000_0000, 1'b1, 1'b0);
    send_frame(wrong_start(), 32'h3F80_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // bad start with bad checksum reports the start
    send_frame(wrong_start(), 32'h1234_5678, 32'h0000_0001, 1'b0, 1'b1);
    send_frame(cur_marker, 32'hDEAD_BEEF, 32'hA5A5_5A5A, 1'b0, 1'b0);
    // restart in mid-frame drops the partial frame
    for (int i = 0; i < 5; i++)
      send_byte(8'($urandom), i == 0);
    send_frame(cur_marker, 32'hC2C8_0000, 32'h0000_0000, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int stop_at;
    int pick;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_frame(($urandom_range(0, 99) < 15) ? wrong_start() : cur_marker,
                   $urandom, $urandom, $urandom_range(0, 99) >= 15,
                   1'($urandom_range(0, 1)));
      end else if (pick < 90) begin
        // truncated frame
        send_byte(($urandom_range(0, 1) != 0) ? cur_marker : 8'($urandom), 1'b1);
        repeat ($urandom_range(0, 9))
          send_byte(8'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 15))
          send_byte(8'($urandom), $urandom_range(0, 5) == 0);
      end
    end
    // close on a frame boundary
    send_frame(cur_marker, $urandom, $urandom, 1'b1, 1'b1);
  endtask

  task automatic test_backpressure();
    hold_left <= 300;
    repeat (10)
      send_frame(cur_marker, $urandom, $urandom, $urandom_range(0, 3) != 0, 1'b0);
    wait_drained();
  endtask

  task automatic test_no_idle(input int n_bytes);
    calm <= 1'b1;
    @(posedge clk);
    test_random_traffic(n_bytes);
    calm <= 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic(300);
    set_marker(8'h00);
    test_random_traffic(250);
    test_backpressure();
    set_marker(8'hFF);
    test_no_idle(250);
    set_marker(8'($urandom));
    test_random_traffic(300);
    set_marker(START_RESET);
    test_random_traffic(150);
    wait_drained();
    repeat (10) @(posedge clk);
    if (frames_due.size() != 0)
      errors++;
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
